// ===== rtl/olst_pkg.sv =====
// olst_pkg: sizes, codes and shared types of the ordered list engine
// no dependencies; every other file of the block depends on this package
package olst_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int ECOUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_SEARCH = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_COUNT  = 3'd3,
		CMD_LIST   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_POS   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_REPORT
	} state_t;

	// controls broadcast from the sequencer to the row of cells
	typedef struct packed {
		logic                      shift;
		logic                      wr_en;
		logic [IDX_W-1:0]          wr_idx;
		logic signed [VALUE_W-1:0] wr_data;
	} chain_ctl_t;

endpackage

// ===== rtl/olst_cmd_if.sv =====
// olst_cmd_if: valid/ready channel carrying command transactions
// depends on olst_pkg for the field widths
interface olst_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [olst_pkg::CMD_W-1:0]         command;
	logic signed [olst_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== rtl/olst_rsp_if.sv =====
// olst_rsp_if: valid/ready channel carrying result transactions
// depends on olst_pkg for the field widths
interface olst_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [olst_pkg::STATUS_W-1:0]       status;
	logic                                found;
	logic [olst_pkg::ECOUNT_W-1:0]       entry_count;
	logic signed [olst_pkg::VALUE_W-1:0] item_value;
	logic                                last;

	modport source (output valid, output status, output found, output entry_count,
		output item_value, output last, input ready);
	modport sink   (input valid, input status, input found, input entry_count,
		input item_value, input last, output ready);
endinterface

// ===== rtl/olst_cell.sv =====
// olst_cell: one list position, holds a value and takes its right neighbor on shift
// depends on olst_pkg
module olst_cell (
	input  logic                                clk,
	input  logic                                shift,
	input  logic                                load,
	input  logic signed [olst_pkg::VALUE_W-1:0] load_data,
	input  logic signed [olst_pkg::VALUE_W-1:0] nbr_value,
	output logic signed [olst_pkg::VALUE_W-1:0] value
);
	import olst_pkg::*;

	logic signed [VALUE_W-1:0] value_q;

	// a load wins over the shift: it is the slot behind the last live entry
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= load_data;
		end else if (shift) begin
			value_q <= nbr_value;
		end
	end

	assign value = value_q;
endmodule

// ===== rtl/olst_chain.sv =====
// olst_chain: row of DEPTH cells, head in cell 0, entries packed toward cell 0
// depends on olst_pkg and olst_cell
module olst_chain (
	input  logic                                clk,
	input  olst_pkg::chain_ctl_t                ctl,
	output logic signed [olst_pkg::VALUE_W-1:0] front
);
	import olst_pkg::*;

	logic signed [VALUE_W-1:0] cell_value [DEPTH];
	logic signed [VALUE_W-1:0] nbr_value  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_end
			assign nbr_value[i] = '0;
		end else begin : g_mid
			assign nbr_value[i] = cell_value[i+1];
		end

		olst_cell u_cell (
			.clk       (clk),
			.shift     (ctl.shift),
			.load      (ctl.wr_en && (ctl.wr_idx == IDX_W'(i))),
			.load_data (ctl.wr_data),
			.nbr_value (nbr_value[i]),
			.value     (cell_value[i])
		);
	end

	assign front = cell_value[0];
endmodule

// ===== rtl/ordered_list_engine_unit.sv =====
// ordered_list_engine_unit: top level of the ordered list engine
// depends on olst_pkg, olst_cmd_if, olst_rsp_if and olst_chain
//
// usage
//   cmd carries one transaction per command (append, search, remove, count,
//   list all), rsp returns the results through a registered output stage.
//   the entries sit in a row of DEPTH cells in arrival order, head in cell 0.
//   append, count and unknown commands finish in the cycle they are taken;
//   the result shows on rsp in the next cycle.
//   search and remove rotate the live entries through the row, one cell
//   step per cycle: the head leaves cell 0 and is written back behind the
//   last live entry, one step per entry, and a report state then sends the result.
//   remove drops the first matching entry instead of writing it back.
//   list all rotates the same way and sends one result per step, N results
//   for N entries, one result per accepted transaction.
//   one command is in work at a time; cmd.ready is high only while idle and
//   the result register is free or being emptied.
//   a stalled rsp holds its result and pauses a listing walk in place.
//   reset empties the list and clears the state, step, hit and valid registers;
//   command, key, result fields and cells are not reset, entries beyond the count are never read.
module ordered_list_engine_unit (
	input  logic         clk,
	input  logic         arst_n,
	olst_cmd_if.sink     cmd,
	olst_rsp_if.source   rsp
);
	import olst_pkg::*;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          steps_q, steps_d;
	cmd_t                      cmd_q, cmd_d;
	logic signed [VALUE_W-1:0] key_q, key_d;
	logic                      hit_q, hit_d;

	// result register
	logic                      rsp_valid_q;
	status_t                   status_q;
	logic                      found_q;
	logic [ECOUNT_W-1:0]       ecount_q;
	logic signed [VALUE_W-1:0] item_q;
	logic                      last_q;

	// result to load this cycle
	logic                      emit;
	status_t                   emit_status;
	logic                      emit_found;
	logic signed [VALUE_W-1:0] emit_item;
	logic                      emit_last;

	chain_ctl_t                ctl;
	logic signed [VALUE_W-1:0] front;

	logic out_free;
	logic cmd_take;
	logic step_en;
	logic match;
	logic drop;
	logic positive;
	logic walk_end;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign cmd_take  = cmd.valid && cmd.ready;
	assign positive  = !cmd.value[VALUE_W-1] && (cmd.value != '0);

	// listing steps only when its result can go out, search/remove every cycle
	assign step_en  = (state_q == S_WALK) && ((cmd_q != CMD_LIST) || out_free);
	assign match    = step_en && (cmd_q != CMD_LIST) && (front == key_q) && !hit_q;
	assign drop     = match && (cmd_q == CMD_REMOVE);
	assign walk_end = step_en && (steps_q == CNT_W'(1));

	olst_chain u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.front (front)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_take && (count_q != '0)) begin
					case (cmd_t'(cmd.command))
						CMD_SEARCH, CMD_REMOVE, CMD_LIST: state_d = S_WALK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WALK: begin
				if (walk_end) begin
					state_d = (cmd_q == CMD_LIST) ? S_IDLE : S_REPORT;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath controls and results
	always_comb begin
		count_d     = count_q;
		steps_d     = steps_q;
		cmd_d       = cmd_q;
		key_d       = key_q;
		hit_d       = hit_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_found  = 1'b0;
		emit_item   = '0;
		emit_last   = 1'b1;
		ctl.shift   = 1'b0;
		ctl.wr_en   = 1'b0;
		ctl.wr_idx  = count_q[IDX_W-1:0];
		ctl.wr_data = cmd.value;
		case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					cmd_d   = cmd_t'(cmd.command);
					key_d   = cmd.value;
					steps_d = count_q;
					hit_d   = 1'b0;
					case (cmd_t'(cmd.command))
						CMD_APPEND: begin
							emit = 1'b1;
							if (!positive) begin
								emit_status = ST_NOT_POS;
							end else if (count_q == CNT_W'(DEPTH)) begin
								emit_status = ST_FULL;
							end else begin
								ctl.wr_en = 1'b1;
								count_d   = count_q + CNT_W'(1);
							end
						end
						CMD_SEARCH, CMD_REMOVE: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_NOT_FOUND;
							end
						end
						CMD_LIST: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_WALK: begin
				if (step_en) begin
					// head leaves cell 0, rejoins behind the last live entry
					ctl.shift   = 1'b1;
					ctl.wr_en   = !drop;
					ctl.wr_idx  = IDX_W'(count_q - CNT_W'(1));
					ctl.wr_data = front;
					steps_d     = steps_q - CNT_W'(1);
					hit_d       = hit_q || match;
					if (drop) begin
						count_d = count_q - CNT_W'(1);
					end
					if (cmd_q == CMD_LIST) begin
						emit      = 1'b1;
						emit_item = front;
						emit_last = (steps_q == CNT_W'(1));
					end
				end
			end
			S_REPORT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_found  = hit_q;
					emit_status = hit_q ? ST_OK : ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			steps_q <= steps_d;
			hit_q   <= hit_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		key_q <= key_d;
		if (emit) begin
			status_q <= emit_status;
			found_q  <= emit_found;
			ecount_q <= ECOUNT_W'(count_d);
			item_q   <= emit_item;
			last_q   <= emit_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found       = found_q;
	assign rsp.entry_count = ecount_q;
	assign rsp.item_value  = item_q;
	assign rsp.last        = last_q;

	// the list never holds more than the row of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// a walk always has steps left
	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (steps_q != '0) && (steps_q <= count_q + CNT_W'(1)))
		else $error("walk without remaining steps");

	// a new result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp.status == $past(rsp.status))
			&& (rsp.item_value == $past(rsp.item_value)))
		else $error("result overwritten while stalled");

	// a good append grows the list by exactly one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && (cmd.command == CMD_APPEND) && positive
			&& (count_q != CNT_W'(DEPTH))) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not add an entry");

	// a walk never grows the list
	a_walk_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |=> (count_q <= $past(count_q)))
		else $error("walk grew the list");
endmodule
